// ===== src/sct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared constants, token kind codes and character classes for the source
// character tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int OUT_BITS          = 16;
  localparam int KIND_BITS         = 5;

  localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_EQ      = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd5;
  localparam logic [KIND_BITS-1:0] KIND_CARET   = 5'd6;
  localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd7;
  localparam logic [KIND_BITS-1:0] KIND_GT      = 5'd8;
  localparam logic [KIND_BITS-1:0] KIND_LT      = 5'd9;
  localparam logic [KIND_BITS-1:0] KIND_COLON   = 5'd10;
  localparam logic [KIND_BITS-1:0] KIND_BANG    = 5'd11;
  localparam logic [KIND_BITS-1:0] KIND_DOT     = 5'd12;
  localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd13;
  localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd14;
  localparam logic [KIND_BITS-1:0] KIND_BRACE   = 5'd15;
  localparam logic [KIND_BITS-1:0] KIND_PAREN   = 5'd16;
  localparam logic [KIND_BITS-1:0] KIND_BRACKET = 5'd17;
  localparam logic [KIND_BITS-1:0] KIND_NEWLINE = 5'd18;
  localparam logic [KIND_BITS-1:0] KIND_END     = 5'd19;
  localparam logic [KIND_BITS-1:0] KIND_INVALID = 5'd20;
  localparam logic [KIND_BITS-1:0] KIND_NONE    = 5'd31;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [KIND_BITS-1:0] symbol_kind(input logic [7:0] c);
    case (c)
      8'h3D:        return KIND_EQ;      // =
      8'h2B:        return KIND_PLUS;    // +
      8'h2D:        return KIND_MINUS;   // -
      8'h2A:        return KIND_STAR;    // *
      8'h5E:        return KIND_CARET;   // ^
      8'h2F:        return KIND_SLASH;   // /
      8'h3E:        return KIND_GT;      // >
      8'h3C:        return KIND_LT;      // <
      8'h3A:        return KIND_COLON;   // :
      8'h21:        return KIND_BANG;    // !
      8'h2E:        return KIND_DOT;     // .
      8'h2C:        return KIND_COMMA;   // ,
      8'h3B:        return KIND_SEMI;    // ;
      8'h7B, 8'h7D: return KIND_BRACE;
      8'h28, 8'h29: return KIND_PAREN;
      8'h5B, 8'h5D: return KIND_BRACKET;
      CH_NEWLINE:   return KIND_NEWLINE;
      default:      return KIND_NONE;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/sct_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front
// Accepts source bytes, tracks line, column and the open word, and turns each
// byte into at most one job record naming the tokens it causes.
// ----------------------------------------------------------------------------
module sct_front #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF,
  parameter int JOB_W         = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       source_byte,
  input  wire logic             end_of_source,
  input  wire logic             q_full,
  output logic                  push,
  output logic [JOB_W-1:0]      push_data
);
  import sct_pkg::*;

  localparam int P = POSITION_BITS;

  typedef struct packed {
    logic                 has_word;
    logic                 word_ident;
    logic [P-1:0]         word_line;
    logic [P-1:0]         word_col;
    logic [P-1:0]         word_len;
    logic                 has_sym;
    logic [KIND_BITS-1:0] sym_kind;
    logic [P-1:0]         sym_line;
    logic [P-1:0]         sym_col;
    logic [7:0]           sym_char;
    logic                 has_end;
    logic [P-1:0]         end_line;
    logic [P-1:0]         end_col;
  } job_t;

  function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
    return (v == '1) ? v : v + P'(1);
  endfunction

  logic         word_open, word_open_next;
  logic         word_ident, word_ident_next;
  logic [P-1:0] word_col, word_col_next;
  logic [P-1:0] word_line, word_line_next;
  logic [P-1:0] word_len, word_len_next;
  logic [P-1:0] cur_line, cur_line_next;
  logic [P-1:0] cur_col, cur_col_next;
  logic         halted, halted_next;

  logic                 fire, nl, alnum, bad;
  logic [P-1:0]         line_now, col_now, col_inc;
  logic [KIND_BITS-1:0] kind;
  job_t                 job;

  // a halted block keeps draining input without a word
  assign in_ready = halted | ~q_full;
  assign fire     = in_valid & in_ready & ~halted;

  always_comb begin
    nl       = (source_byte == CH_NEWLINE);
    alnum    = is_letter(source_byte) | is_digit(source_byte);
    kind     = symbol_kind(source_byte);
    line_now = nl ? sat_inc(cur_line) : cur_line;
    col_now  = nl ? '0 : cur_col;
    col_inc  = sat_inc(col_now);
    bad      = 1'b0;

    word_open_next  = word_open;
    word_ident_next = word_ident;
    word_col_next   = word_col;
    word_line_next  = word_line;
    word_len_next   = word_len;
    cur_line_next   = line_now;
    cur_col_next    = col_inc;
    halted_next     = halted;
    job             = '0;

    if (alnum) begin
      if (!word_open) begin
        word_open_next  = 1'b1;
        word_ident_next = is_letter(source_byte);
        word_col_next   = col_now;
        word_line_next  = line_now;
        word_len_next   = P'(1);
      end else begin
        word_len_next = sat_inc(word_len);
      end
    end else begin
      // flush the open word before the character itself
      if (word_open) begin
        job.has_word   = 1'b1;
        job.word_ident = word_ident;
        job.word_line  = word_line;
        job.word_col   = word_col;
        job.word_len   = word_len;
      end
      word_open_next = 1'b0;
      word_len_next  = '0;
      if (source_byte != CH_SPACE && source_byte != CH_TAB) begin
        job.has_sym  = 1'b1;
        job.sym_line = line_now;
        job.sym_col  = col_now;
        job.sym_char = source_byte;
        if (kind == KIND_NONE) begin
          bad          = 1'b1;
          job.sym_kind = KIND_INVALID;
          halted_next  = 1'b1;
        end else begin
          job.sym_kind = kind;
        end
      end
    end

    if (end_of_source && !bad) begin
      if (word_open_next) begin
        job.has_word   = 1'b1;
        job.word_ident = word_ident_next;
        job.word_line  = word_line_next;
        job.word_col   = word_col_next;
        job.word_len   = word_len_next;
      end
      job.has_end  = 1'b1;
      job.end_line = line_now;
      job.end_col  = col_inc;
      // start a new source
      word_open_next  = 1'b0;
      word_ident_next = 1'b0;
      word_col_next   = '0;
      word_line_next  = P'(1);
      word_len_next   = '0;
      cur_line_next   = P'(1);
      cur_col_next    = '0;
    end
  end

  assign push      = fire & (job.has_word | job.has_sym | job.has_end);
  assign push_data = JOB_W'(job);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_open  <= 1'b0;
      word_ident <= 1'b0;
      word_col   <= '0;
      word_line  <= P'(1);
      word_len   <= '0;
      cur_line   <= P'(1);
      cur_col    <= '0;
      halted     <= 1'b0;
    end else if (fire) begin
      word_open  <= word_open_next;
      word_ident <= word_ident_next;
      word_col   <= word_col_next;
      word_line  <= word_line_next;
      word_len   <= word_len_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
      halted     <= halted_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/sct_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sct_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/sct_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back
// Expands the job at the head of the queue into its tokens, one per cycle while
// out_ready holds, into a registered output stage.
// ----------------------------------------------------------------------------
module sct_back #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF,
  parameter int JOB_W         = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_empty,
  input  wire logic [JOB_W-1:0]               head_data,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [sct_pkg::KIND_BITS-1:0]       token_kind,
  output logic [sct_pkg::OUT_BITS-1:0]        token_line,
  output logic [sct_pkg::OUT_BITS-1:0]        token_column,
  output logic [sct_pkg::OUT_BITS-1:0]        token_length,
  output logic [7:0]                          token_char,
  output logic                                last_result
);
  import sct_pkg::*;

  localparam int P = POSITION_BITS;

  typedef struct packed {
    logic                 has_word;
    logic                 word_ident;
    logic [P-1:0]         word_line;
    logic [P-1:0]         word_col;
    logic [P-1:0]         word_len;
    logic                 has_sym;
    logic [KIND_BITS-1:0] sym_kind;
    logic [P-1:0]         sym_line;
    logic [P-1:0]         sym_col;
    logic [7:0]           sym_char;
    logic                 has_end;
    logic [P-1:0]         end_line;
    logic [P-1:0]         end_col;
  } job_t;

  function automatic logic [OUT_BITS-1:0] clip(input logic [P-1:0] v);
    logic [P+OUT_BITS-1:0] w;
    w = {{OUT_BITS{1'b0}}, v};
    if (w > (P + OUT_BITS)'({OUT_BITS{1'b1}})) begin
      return '1;
    end
    return w[OUT_BITS-1:0];
  endfunction

  job_t     head;
  logic [2:0] done, avail, sel, rest;
  logic       load;

  logic [KIND_BITS-1:0] kind_sel;
  logic [P-1:0]         line_sel, col_sel, len_sel;
  logic [7:0]           char_sel;

  assign head  = job_t'(head_data);
  assign avail = {head.has_end, head.has_sym, head.has_word} & ~done;

  // word first, then the character token, then the end token
  always_comb begin
    sel      = '0;
    kind_sel = KIND_END;
    line_sel = head.end_line;
    col_sel  = head.end_col;
    len_sel  = '0;
    char_sel = '0;
    if (avail[0]) begin
      sel      = 3'b001;
      kind_sel = head.word_ident ? KIND_IDENT : KIND_INT;
      line_sel = head.word_line;
      col_sel  = head.word_col;
      len_sel  = head.word_len;
    end else if (avail[1]) begin
      sel      = 3'b010;
      kind_sel = head.sym_kind;
      line_sel = head.sym_line;
      col_sel  = head.sym_col;
      len_sel  = P'(1);
      char_sel = head.sym_char;
    end else if (avail[2]) begin
      sel = 3'b100;
    end
    rest = avail & ~sel;
  end

  assign load = ~q_empty & (~out_valid | out_ready);
  assign pop  = load & (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= (rest == '0) ? '0 : (done | sel);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind   <= kind_sel;
      token_line   <= clip(line_sel);
      token_column <= clip(col_sel);
      token_length <= clip(len_sel);
      token_char   <= char_sel;
      last_result  <= (rest == '0);
    end
  end

endmodule
`default_nettype wire

// ===== src/source_char_tokenizer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// source_char_tokenizer_core
// Byte-stream lexical tokenizer: words, integers, operator and symbol tokens,
// an end token per source and an invalid token that halts until reset.
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   input    | in_valid / in_ready   | source_byte, end_of_source
//   output   | out_valid / out_ready | token_kind, token_line, token_column,
//            |                       | token_length, token_char, last_result
//
// One byte is accepted per cycle while the queue has room; its job enters
// the queue the same edge. The back part delivers one token per cycle while
// out_ready holds, so a byte that causes two or three tokens holds the back
// part until all are out; the job queue (QUEUE_DEPTH entries) absorbs that,
// and input stalls only when it is full. Reset is synchronous and clears
// position, word and halt state; after an invalid byte input keeps being
// accepted and dropped until reset.
// ----------------------------------------------------------------------------
module source_char_tokenizer_core #(
  parameter int POSITION_BITS = sct_pkg::POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = sct_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    source_byte,
  input  wire logic                          end_of_source,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [sct_pkg::KIND_BITS-1:0]      token_kind,
  output logic [sct_pkg::OUT_BITS-1:0]       token_line,
  output logic [sct_pkg::OUT_BITS-1:0]       token_column,
  output logic [sct_pkg::OUT_BITS-1:0]       token_length,
  output logic [7:0]                         token_char,
  output logic                               last_result
);
  import sct_pkg::*;

  // three has flags, the word kind bit, kind, char, and seven position fields
  localparam int JOB_W = 4 + KIND_BITS + 8 + 7 * POSITION_BITS;

  logic             push, pop, q_full, q_empty;
  logic [JOB_W-1:0] push_data, head_data;

  sct_front #(
    .POSITION_BITS(POSITION_BITS),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_byte  (source_byte),
    .end_of_source(end_of_source),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  sct_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .pop_data (head_data),
    .empty    (q_empty)
  );

  sct_back #(
    .POSITION_BITS(POSITION_BITS),
    .JOB_W        (JOB_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head_data   (head_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .token_kind  (token_kind),
    .token_line  (token_line),
    .token_column(token_column),
    .token_length(token_length),
    .token_char  (token_char),
    .last_result (last_result)
  );

endmodule
`default_nettype wire
